[src/jdht_pkg.sv]
// Package for the JPEG DHT canonical code builder.
// Holds shared constants, parse/sequencer enums and RAM port structs.
// No dependencies.
`default_nettype none

package jdht_pkg;

    // Code lengths in a DHT table (one count byte per length)
    localparam int NUM_LENGTHS      = 16;
    localparam int LEN_IDX_W        = 4;
    localparam int MAX_CODE_LENGTH  = 16;
    localparam int MAX_TABLES_DEF   = 4;

    // Code counter width and its saturation value
    localparam int          CODE_W   = 17;
    localparam logic [16:0] CODE_SAT = 17'h1FFFF;
    localparam logic [16:0] CODE_HALF = 17'h0FFFF;

    localparam int SYMS_W      = 12;
    localparam int LEN_W       = 5;
    localparam int OUT_TDATA_W = 40;

    // Where the parser stands within the segment body
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COUNTS,
        PH_SYMBOLS
    } phase_t;

    // Sequencer: wait for an item, or evaluate a symbol against the count RAM
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EVAL
    } seq_state_t;

    typedef struct packed {
        logic                 en;
        logic [LEN_IDX_W-1:0] addr;
        logic [7:0]           data;
    } ram_wr_t;

    typedef struct packed {
        logic                 en;
        logic [LEN_IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

`default_nettype wire

[src/jpeg_dht_canonical_code_builder.sv]
// Top level of the JPEG DHT canonical code builder.
// Depends on jdht_pkg and jdht_count_ram.
//
// Usage:
//   Input stream (s_axis_*): one byte of the DHT segment body per item,
//   s_axis_tlast marks the final byte of the segment.
//   Output stream (m_axis_*): one item per symbol byte with the slot,
//   class/id byte, symbol, canonical code and code length; tuser flags a
//   bad table (slot beyond MAX_TABLES or code overflowing its length).
//   Header and count bytes produce no output item.
// Timing:
//   Header and count bytes are accepted in the idle state. A symbol byte
//   starts a count RAM read, then waits in evaluation through every empty
//   code length skipped before it, since each length step waits on the
//   count RAM's registered read. The result sits in an output register,
//   and no new byte is accepted until the result has been loaded there.
// Reset:
//   rst_n clears the parser to expect a table header at slot zero and drops
//   any pending output item. The count RAM is not cleared; all 16 counts of
//   a table are written before any symbol reads them.
// Stalls:
//   While the output register is full and m_axis_tready is low, a symbol
//   in evaluation waits and s_axis_tready stays low.
`default_nettype none

module jpeg_dht_canonical_code_builder #(
    parameter int MAX_TABLES = jdht_pkg::MAX_TABLES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata: data_byte[7:0]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // tdata: table_slot[1:0], table_class_id[9:2], symbol[17:10],
    //        code_bits[33:18], code_length[38:34], zero pad[39]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [jdht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: bad_table[0]
    output logic [0:0]       m_axis_tuser
);

    localparam int SLOT_W = $clog2(MAX_TABLES + 1);
    localparam int CW     = jdht_pkg::CODE_W;
    localparam int SW     = jdht_pkg::SYMS_W;
    localparam int LW     = jdht_pkg::LEN_W;
    localparam int IW     = jdht_pkg::LEN_IDX_W;

    // State registers
    jdht_pkg::seq_state_t state_reg, state_next;
    jdht_pkg::phase_t     phase_reg, phase_next;
    logic [LW-1:0]     cnt_idx_reg, cnt_idx_next;
    logic [SW-1:0]     syms_left_reg, syms_left_next;
    logic [LW-1:0]     cur_len_reg, cur_len_next;
    logic [CW-1:0]     code_reg, code_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]        class_reg, class_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [jdht_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                           out_bad_reg, out_bad_next;

    // RAM interface
    jdht_pkg::ram_wr_t ram_wr;
    jdht_pkg::ram_rd_t ram_rd;
    logic [7:0]        rd_data;

    // Helpers
    logic              out_free;
    logic              do_done;
    logic              do_restart;
    logic [SW-1:0]     syms_sum;
    logic [LW-1:0]     cnt_inc;
    logic [LW-1:0]     len_m1;
    logic [CW-1:0]     code_shifted;
    logic [CW-1:0]     code_inc;
    logic [SW-1:0]     syms_dec;
    logic              bad;

    jdht_count_ram u_count_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (rd_data)
    );

    // Datapath helpers
    always_comb
    begin
        out_free     = !out_valid_reg || m_axis_tready;
        syms_sum     = syms_left_reg + SW'(s_axis_tdata);
        cnt_inc      = cnt_idx_reg + LW'(1);
        len_m1       = cur_len_reg - LW'(1);
        code_shifted = (code_reg >= jdht_pkg::CODE_HALF) ? jdht_pkg::CODE_SAT
                                                         : {code_reg[CW-2:0], 1'b0};
        code_inc     = (code_reg < jdht_pkg::CODE_SAT) ? code_reg + CW'(1) : code_reg;
        syms_dec     = (syms_left_reg != '0) ? syms_left_reg - SW'(1) : syms_left_reg;
        bad          = (slot_reg >= SLOT_W'(MAX_TABLES))
                    || ((code_reg >> cur_len_reg) != '0)
                    || (cur_len_reg > LW'(jdht_pkg::MAX_CODE_LENGTH));
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_idx_next   = cnt_idx_reg;
        syms_left_next = syms_left_reg;
        cur_len_next   = cur_len_reg;
        code_next      = code_reg;
        slot_next      = slot_reg;
        class_next     = class_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_bad_next   = out_bad_reg;
        ram_wr         = '0;
        ram_rd         = '0;
        s_axis_tready  = 1'b0;
        do_done        = 1'b0;
        do_restart     = 1'b0;

        case (state_reg)
            jdht_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    case (phase_reg)
                        jdht_pkg::PH_HEADER:
                        begin
                            class_next     = s_axis_tdata;
                            cnt_idx_next   = '0;
                            syms_left_next = '0;
                            phase_next     = jdht_pkg::PH_COUNTS;
                        end
                        jdht_pkg::PH_COUNTS:
                        begin
                            ram_wr.en      = 1'b1;
                            ram_wr.addr    = cnt_idx_reg[IW-1:0];
                            ram_wr.data    = s_axis_tdata;
                            syms_left_next = syms_sum;
                            cnt_idx_next   = cnt_inc;
                            if (cnt_inc >= LW'(jdht_pkg::NUM_LENGTHS))
                            begin
                                cur_len_next = LW'(1);
                                code_next    = '0;
                                if (syms_sum == '0)
                                begin
                                    do_done = 1'b1;
                                end
                                else
                                begin
                                    phase_next = jdht_pkg::PH_SYMBOLS;
                                end
                            end
                        end
                        jdht_pkg::PH_SYMBOLS:
                        begin
                            // Look up the count at the current length
                            byte_next   = s_axis_tdata;
                            last_next   = s_axis_tlast;
                            ram_rd.en   = 1'b1;
                            ram_rd.addr = len_m1[IW-1:0];
                            state_next  = jdht_pkg::ST_EVAL;
                        end
                        default:
                        begin
                            phase_next = jdht_pkg::PH_HEADER;
                        end
                    endcase
                    if (s_axis_tlast && phase_reg != jdht_pkg::PH_SYMBOLS)
                    begin
                        do_restart = 1'b1;
                    end
                end
            end
            jdht_pkg::ST_EVAL:
            begin
                if (cur_len_reg < LW'(jdht_pkg::NUM_LENGTHS) && rd_data == 8'd0)
                begin
                    // Skip an empty length: shift code, read the next count
                    ram_rd.en    = 1'b1;
                    ram_rd.addr  = cur_len_reg[IW-1:0];
                    cur_len_next = cur_len_reg + LW'(1);
                    code_next    = code_shifted;
                end
                else if (out_free)
                begin
                    // Emit the code, consume one count at this length
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, cur_len_reg, code_reg[15:0], byte_reg,
                                      class_reg, 2'(slot_reg)};
                    out_bad_next   = bad;
                    ram_wr.en      = 1'b1;
                    ram_wr.addr    = len_m1[IW-1:0];
                    ram_wr.data    = (rd_data != 8'd0) ? rd_data - 8'd1 : rd_data;
                    code_next      = code_inc;
                    syms_left_next = syms_dec;
                    if (syms_dec == '0)
                    begin
                        do_done = 1'b1;
                    end
                    do_restart = last_reg;
                    state_next = jdht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jdht_pkg::ST_IDLE;
            end
        endcase

        // Table complete: back to header, use up a slot
        if (do_done)
        begin
            phase_next   = jdht_pkg::PH_HEADER;
            cnt_idx_next = '0;
            if (slot_reg < SLOT_W'(MAX_TABLES))
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end

        // Segment end: back to slot zero
        if (do_restart)
        begin
            phase_next     = jdht_pkg::PH_HEADER;
            cnt_idx_next   = '0;
            syms_left_next = '0;
            cur_len_next   = LW'(1);
            code_next      = '0;
            slot_next      = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jdht_pkg::ST_IDLE;
            phase_reg     <= jdht_pkg::PH_HEADER;
            cnt_idx_reg   <= '0;
            syms_left_reg <= '0;
            cur_len_reg   <= LW'(1);
            code_reg      <= '0;
            slot_reg      <= '0;
            class_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_idx_reg   <= cnt_idx_next;
            syms_left_reg <= syms_left_next;
            cur_len_reg   <= cur_len_next;
            code_reg      <= code_next;
            slot_reg      <= slot_next;
            class_reg     <= class_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        out_data_reg <= out_data_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_bad_reg;

endmodule

`default_nettype wire

[src/jdht_count_ram.sv]
// Per-length code count RAM: 16 x 8, one write and one read port.
// Read data is registered. Depends on jdht_pkg.
`default_nettype none

module jdht_count_ram (
    input  wire logic             clk,
    input  wire jdht_pkg::ram_wr_t wr,
    input  wire jdht_pkg::ram_rd_t rd,
    output logic [7:0]            rd_data
);

    logic [7:0] mem [jdht_pkg::NUM_LENGTHS];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/jdht_checker.sv]
// Port-level checks for the JPEG DHT canonical code builder, with bind.
// Depends on jpeg_dht_canonical_code_builder.
`default_nettype none

module jdht_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    logic [4:0]  len;
    logic [15:0] code;

    assign len  = m_axis_tdata[38:34];
    assign code = m_axis_tdata[33:18];

    // No output item while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // A stalled output item stays offered
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    // Code length is always 1..16
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (len != 5'd0) && (len <= 5'd16))
        else $error("code length out of range");

    // A good code fits in its length
    a_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> ({1'b0, code} >> len) == 17'd0)
        else $error("code wider than its length without bad flag");

endmodule

bind jpeg_dht_canonical_code_builder jdht_checker u_jdht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
